@@ rtl/core/assu_pkg.sv @@
`default_nettype none

package assu_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths
    localparam int IN_W   = 32;
    localparam int RES_W  = 32;
    localparam int POS_W  = 7;
    localparam int CAP_W  = 7;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(5);

    // Operation kinds
    localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] K_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] K_SEARCH = 2'd2;
    localparam logic [KIND_W-1:0] K_SORT   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // Read address select
    localparam logic [1:0] RD_OCC_M1 = 2'd0;
    localparam logic [1:0] RD_I      = 2'd1;
    localparam logic [1:0] RD_I1     = 2'd2;
    localparam logic [1:0] RD_ZERO   = 2'd3;

    // Write select
    localparam logic [1:0] WR_INSERT = 2'd0;
    localparam logic [1:0] WR_PASS   = 2'd1;
    localparam logic [1:0] WR_TAIL   = 2'd2;

    // Index register operation
    localparam logic [1:0] I_HOLD = 2'd0;
    localparam logic [1:0] I_CLR  = 2'd1;
    localparam logic [1:0] I_INC  = 2'd2;

    // Staging source
    localparam logic [1:0] SS_CODE = 2'd0;
    localparam logic [1:0] SS_IN   = 2'd1;
    localparam logic [1:0] SS_RD   = 2'd2;
    localparam logic [1:0] SS_POS  = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic              op_load;
        logic              occ_inc;
        logic              occ_dec;
        logic [1:0]        i_op;
        logic              end_load;
        logic              end_dec;
        logic [1:0]        rd_sel;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic              carry_load;
        logic              carry_step;
        logic              st_load;
        logic [1:0]        st_sel;
        logic [STAT_W-1:0] st_status;
        logic              st_last;
        logic              push;
    } t_dp_cmd;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic             occ_one;
        logic             match;
        logic             i_last;
        logic             j_end;
        logic             end_one;
        logic             space;
        logic [OCC_W-1:0] occ;
    } t_dp_sts;

    // Sign-extend or cut a stored entry to the result width
    function automatic logic [RES_W-1:0] to_result(input t_data v);
        return RES_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/assu_ram.sv @@
`default_nettype none

module assu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/assu_dp.sv @@
`default_nettype none

module assu_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire assu_pkg::t_dp_cmd            i_cmd,
    output assu_pkg::t_dp_sts                 o_sts,
    input  wire logic [assu_pkg::CAP_W-1:0]   i_capacity,
    input  wire logic [assu_pkg::IN_W-1:0]    i_operand,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic      [assu_pkg::STAT_W-1:0]  o_out_status,
    output logic      [assu_pkg::RES_W-1:0]   o_out_value,
    output logic      [assu_pkg::POS_W-1:0]   o_out_pos,
    output logic                              o_out_last
);

    import assu_pkg::*;

    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_end;
    t_data             r_op;
    t_data             r_carry;
    logic [STAT_W-1:0] r_st_status;
    logic [RES_W-1:0]  r_st_value;
    logic [POS_W-1:0]  r_st_pos;
    logic              r_st_last;
    logic              r_ov;

    logic [OCC_W-1:0]      w_occ_m1;
    logic [OCC_W-1:0]      w_i1;
    logic [CAP_W-1:0]      w_limit_cap;
    logic [CMP_W-1:0]      w_limit;
    t_data                 w_in_op;
    t_data                 w_rdata;
    logic [DATA_WIDTH-1:0] w_ram_q;
    logic [IDX_W-1:0]      w_raddr;
    logic [IDX_W-1:0]      w_waddr;
    t_data                 w_wdata;
    logic                  w_greater;

    assign w_occ_m1 = r_occ - OCC_W'(1);
    assign w_i1     = r_i + OCC_W'(1);
    assign w_in_op  = DATA_WIDTH'($signed(i_operand));
    assign w_rdata  = $signed(w_ram_q);
    assign w_greater = r_carry > w_rdata;

    // Saturate the capacity at the store depth
    assign w_limit_cap = i_capacity;
    assign w_limit = (CMP_W'(w_limit_cap) < CMP_W'(DEPTH)) ? CMP_W'(w_limit_cap)
                                                            : CMP_W'(DEPTH);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_OCC_M1: w_raddr = w_occ_m1[IDX_W-1:0];
            RD_I:      w_raddr = r_i[IDX_W-1:0];
            RD_I1:     w_raddr = w_i1[IDX_W-1:0];
            default:   w_raddr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_INSERT: begin
                w_waddr = r_occ[IDX_W-1:0];
                w_wdata = w_in_op;
            end
            WR_PASS: begin
                w_waddr = r_i[IDX_W-1:0];
                w_wdata = w_greater ? w_rdata : r_carry;
            end
            default: begin
                w_waddr = r_end;
                w_wdata = r_carry;
            end
        endcase
    end

    assu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.occ_inc) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (i_cmd.occ_dec) begin
                r_occ <= w_occ_m1;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.i_op)
            I_CLR:   r_i <= '0;
            I_INC:   r_i <= w_i1;
            default: r_i <= r_i;
        endcase
        if (i_cmd.end_load) begin
            r_end <= w_occ_m1[IDX_W-1:0];
        end else if (i_cmd.end_dec) begin
            r_end <= r_end - IDX_W'(1);
        end
        if (i_cmd.op_load) begin
            r_op <= w_in_op;
        end
        // Hold the larger value and carry it to the end of the pass
        if (i_cmd.carry_load) begin
            r_carry <= w_rdata;
        end else if (i_cmd.carry_step && !w_greater) begin
            r_carry <= w_rdata;
        end
        if (i_cmd.st_load) begin
            r_st_last <= i_cmd.st_last;
            case (i_cmd.st_sel)
                SS_CODE: begin
                    r_st_status <= i_cmd.st_status;
                    r_st_value  <= '0;
                    r_st_pos    <= '0;
                end
                SS_IN: begin
                    r_st_status <= ST_OK;
                    r_st_value  <= to_result(w_in_op);
                    r_st_pos    <= '0;
                end
                SS_RD: begin
                    r_st_status <= ST_OK;
                    r_st_value  <= to_result(w_rdata);
                    r_st_pos    <= '0;
                end
                default: begin
                    r_st_status <= ST_OK;
                    r_st_value  <= to_result(w_rdata);
                    r_st_pos    <= POS_W'(w_i1);
                end
            endcase
        end
        if (i_cmd.push) begin
            o_out_status <= r_st_status;
            o_out_value  <= r_st_value;
            o_out_pos    <= r_st_pos;
            o_out_last   <= r_st_last;
        end
    end

    assign o_out_valid = r_ov;

    assign o_sts.full    = CMP_W'(r_occ) >= w_limit;
    assign o_sts.empty   = (r_occ == '0);
    assign o_sts.occ_one = (r_occ == OCC_W'(1));
    assign o_sts.match   = (w_rdata == r_op);
    assign o_sts.i_last  = (w_i1 == r_occ);
    assign o_sts.j_end   = (w_i1 == OCC_W'(r_end));
    assign o_sts.end_one = (r_end == IDX_W'(1));
    assign o_sts.space   = !r_ov || i_out_ready;
    assign o_sts.occ     = r_occ;

endmodule

`default_nettype wire

@@ rtl/core/assu_ctrl.sv @@
`default_nettype none

module assu_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [assu_pkg::KIND_W-1:0] i_kind,
    input  wire assu_pkg::t_dp_sts           i_sts,
    output logic                             o_in_ready,
    output assu_pkg::t_dp_cmd                o_cmd
);

    import assu_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEL   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_PST   = 4'd4;
    localparam logic [3:0] S_PLD   = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PCMP  = 4'd7;
    localparam logic [3:0] S_PTAIL = 4'd8;
    localparam logic [3:0] S_LRD   = 4'd9;
    localparam logic [3:0] S_LDAT  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] r_ret;
    logic [3:0] n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.st_last = 1'b1;
                    n_ret         = S_IDLE;
                    unique case (i_kind)
                        K_INSERT: begin
                            o_cmd.st_load = 1'b1;
                            n_state       = S_EMIT;
                            if (i_sts.full) begin
                                o_cmd.st_sel    = SS_CODE;
                                o_cmd.st_status = ST_FULL;
                            end else begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.wr_sel  = WR_INSERT;
                                o_cmd.occ_inc = 1'b1;
                                o_cmd.st_sel  = SS_IN;
                            end
                        end
                        K_DELETE: begin
                            if (i_sts.empty) begin
                                o_cmd.st_load   = 1'b1;
                                o_cmd.st_sel    = SS_CODE;
                                o_cmd.st_status = ST_EMPTY;
                                n_state         = S_EMIT;
                            end else begin
                                o_cmd.rd_sel  = RD_OCC_M1;
                                o_cmd.occ_dec = 1'b1;
                                n_state       = S_DEL;
                            end
                        end
                        K_SEARCH: begin
                            o_cmd.op_load = 1'b1;
                            o_cmd.i_op    = I_CLR;
                            if (i_sts.empty) begin
                                o_cmd.st_load   = 1'b1;
                                o_cmd.st_sel    = SS_CODE;
                                o_cmd.st_status = ST_NOTFOUND;
                                n_state         = S_EMIT;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        default: begin
                            o_cmd.i_op     = I_CLR;
                            o_cmd.end_load = 1'b1;
                            if (i_sts.empty) begin
                                o_cmd.st_load   = 1'b1;
                                o_cmd.st_sel    = SS_CODE;
                                o_cmd.st_status = ST_EMPTY;
                                n_state         = S_EMIT;
                            end else if (i_sts.occ_one) begin
                                n_state = S_LRD;
                            end else begin
                                n_state = S_PST;
                            end
                        end
                    endcase
                end
            end
            S_DEL: begin
                o_cmd.st_load = 1'b1;
                o_cmd.st_sel  = SS_RD;
                o_cmd.st_last = 1'b1;
                n_ret         = S_IDLE;
                n_state       = S_EMIT;
            end
            S_SRD: begin
                o_cmd.rd_sel = RD_I;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.st_last = 1'b1;
                n_ret         = S_IDLE;
                if (i_sts.match) begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_sel  = SS_POS;
                    n_state       = S_EMIT;
                end else if (i_sts.i_last) begin
                    o_cmd.st_load   = 1'b1;
                    o_cmd.st_sel    = SS_CODE;
                    o_cmd.st_status = ST_NOTFOUND;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.i_op = I_INC;
                    n_state    = S_SRD;
                end
            end
            S_PST: begin
                o_cmd.rd_sel = RD_ZERO;
                n_state      = S_PLD;
            end
            S_PLD: begin
                o_cmd.carry_load = 1'b1;
                n_state          = S_PRD;
            end
            S_PRD: begin
                o_cmd.rd_sel = RD_I1;
                n_state      = S_PCMP;
            end
            S_PCMP: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_sel     = WR_PASS;
                o_cmd.carry_step = 1'b1;
                o_cmd.i_op       = I_INC;
                n_state          = i_sts.j_end ? S_PTAIL : S_PRD;
            end
            S_PTAIL: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_TAIL;
                o_cmd.end_dec = 1'b1;
                o_cmd.i_op    = I_CLR;
                n_state       = i_sts.end_one ? S_LRD : S_PST;
            end
            S_LRD: begin
                o_cmd.rd_sel = RD_I;
                n_state      = S_LDAT;
            end
            S_LDAT: begin
                o_cmd.st_load = 1'b1;
                o_cmd.st_sel  = SS_POS;
                o_cmd.st_last = i_sts.i_last;
                o_cmd.i_op    = I_INC;
                n_ret         = i_sts.i_last ? S_IDLE : S_LRD;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.space) begin
                    o_cmd.push = 1'b1;
                    n_state    = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/array_stack_search_sort_unit.sv @@
// Array stack with linear search and in-place ascending sort.
//
// Input words (s_axis) carry an operation kind in tuser (insert, delete,
// search, sort-and-list) and the operand in tdata. Result words (m_axis)
// carry the status in tuser, value and 1-based position in tdata, and
// tlast marks the final result of each input word. Capacity is written
// over the APB port at address 0; pready is always high.
// Steps, from accepting a word to loading its result into the output
// register:
//   insert, delete          : stage the result; a delete reads the top first
//   search                  : a read and a compare per entry examined
//   sort and list           : passes in which each compare-and-move takes
//                             a read and a compare-and-write state on the
//                             single-read-port entry RAM, then a read and
//                             a staging step per listed word
// One word is processed at a time; s_axis_tready is high only while the
// sequencer is idle, even if the last result still waits downstream.
// Reset clears occupancy and the sequencer and sets capacity to 5; RAM
// contents are not cleared, and need not be. A stalled receiver holds the
// output register and the sequencer simply waits before the next result.
`default_nettype none

module array_stack_search_sort_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] operand_value
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // [31:0] result_value, [38:32] found_position
    output logic      [1:0]  m_axis_tuser,  // [1:0] status
    output logic             m_axis_tlast,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import assu_pkg::*;

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    logic [CAP_W-1:0] r_capacity;
    logic             w_cfg_wr;
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [RES_W-1:0] w_out_value;
    logic [POS_W-1:0] w_out_pos;

    // Config access: write completes on the access cycle
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    assign prdata   = (paddr == ADDR_CAPACITY) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    assu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_capacity   (r_capacity),
        .i_operand    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_value  (w_out_value),
        .o_out_pos    (w_out_pos),
        .o_out_last   (m_axis_tlast)
    );

    // Pack value low, position above it, pad to whole bytes
    assign m_axis_tdata = {1'b0, w_out_pos, w_out_value};

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.occ <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == K_INSERT) && !w_sts.full
        |=> w_sts.occ == OCC_W'($past(w_sts.occ) + OCC_W'(1)))
        else $error("insert did not advance occupancy");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == K_DELETE) && !w_sts.empty
        |=> w_sts.occ == OCC_W'($past(w_sts.occ) - OCC_W'(1)))
        else $error("delete did not drop occupancy");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast)
        else $error("error status on a non-final result");
`endif

endmodule

`default_nettype wire
